@@ rtl/u8dec_pkg.sv @@
// shared types and constants for the utf-8 code point decoder
package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 31;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned FLAG_W = 3;
  localparam int unsigned TDATA_OUT_W = ((CP_W + LEN_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] LEN_ONE = 3'd1;

  // newline code points
  localparam logic [CP_W-1:0] CP_LF  = 31'h0000_000A;
  localparam logic [CP_W-1:0] CP_VT  = 31'h0000_000B;
  localparam logic [CP_W-1:0] CP_FF  = 31'h0000_000C;
  localparam logic [CP_W-1:0] CP_CR  = 31'h0000_000D;
  localparam logic [CP_W-1:0] CP_NEL = 31'h0000_0085;
  localparam logic [CP_W-1:0] CP_LS  = 31'h0000_2028;
  localparam logic [CP_W-1:0] CP_PS  = 31'h0000_2029;

  // whitespace code points
  localparam logic [CP_W-1:0] CP_NUL      = 31'h0000_0000;
  localparam logic [CP_W-1:0] CP_TAB      = 31'h0000_0009;
  localparam logic [CP_W-1:0] CP_SPACE    = 31'h0000_0020;
  localparam logic [CP_W-1:0] CP_NBSP     = 31'h0000_00A0;
  localparam logic [CP_W-1:0] CP_OGHAM    = 31'h0000_1680;
  localparam logic [CP_W-1:0] CP_EN_QUAD  = 31'h0000_2000;
  localparam logic [CP_W-1:0] CP_HAIR_SP  = 31'h0000_200A;
  localparam logic [CP_W-1:0] CP_NNBSP    = 31'h0000_202F;
  localparam logic [CP_W-1:0] CP_MMSP     = 31'h0000_205F;
  localparam logic [CP_W-1:0] CP_IDEO_SP  = 31'h0000_3000;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] byte_count;
    logic             stray_byte;
  } u8dec_seq_res_t;

  typedef struct packed {
    logic is_whitespace;
    logic is_newline;
  } u8dec_flags_t;

endpackage

@@ rtl/u8dec_seq.sv @@
// sequence assembler: lead byte decode, continuation shift-in, completion
module u8dec_seq
  import u8dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              res_vld,
  output u8dec_seq_res_t    res
);

  logic [CP_W-1:0]  partial_r, partial_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] seq_len_r, seq_len_nxt;
  logic [CP_W-1:0]  shifted;

  assign shifted = {partial_r[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    partial_nxt = partial_r;
    left_nxt    = left_r;
    seq_len_nxt = seq_len_r;
    res_vld     = 1'b0;
    res         = '{code_point: '0, byte_count: LEN_ONE, stray_byte: 1'b0};
    if (left_r != '0) begin
      partial_nxt    = shifted;
      left_nxt       = left_r - LEN_ONE;
      res_vld        = (left_r == LEN_ONE);
      res.code_point = shifted;
      res.byte_count = seq_len_r;
    end else if (data_byte[7:6] == 2'b10) begin
      res_vld        = 1'b1;
      res.stray_byte = 1'b1;
    end else if (!data_byte[7]) begin
      res_vld        = 1'b1;
      res.code_point = {{(CP_W-BYTE_W){1'b0}}, data_byte};
    end else begin
      // lead byte: count of leading ones after 11 sets the length
      unique casez (data_byte[5:2])
        4'b0???: begin
          seq_len_nxt = 3'd2;
          partial_nxt = {{(CP_W-5){1'b0}}, data_byte[4:0]};
        end
        4'b10??: begin
          seq_len_nxt = 3'd3;
          partial_nxt = {{(CP_W-4){1'b0}}, data_byte[3:0]};
        end
        4'b110?: begin
          seq_len_nxt = 3'd4;
          partial_nxt = {{(CP_W-3){1'b0}}, data_byte[2:0]};
        end
        4'b1110: begin
          seq_len_nxt = 3'd5;
          partial_nxt = {{(CP_W-2){1'b0}}, data_byte[1:0]};
        end
        default: begin
          seq_len_nxt = 3'd6;
          partial_nxt = {{(CP_W-1){1'b0}}, data_byte[0]};
        end
      endcase
      left_nxt = seq_len_nxt - LEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r    <= '0;
      seq_len_r <= '0;
    end else if (step) begin
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
      seq_len_r <= seq_len_nxt;
    end
  end

endmodule

@@ rtl/u8dec_class.sv @@
// code point classifier: newline and whitespace flags
module u8dec_class
  import u8dec_pkg::*;
(
  input  logic            count_newlines,
  input  logic [CP_W-1:0] code_point,
  output u8dec_flags_t    flags
);

  logic nl;
  logic sp;

  always_comb begin
    nl = (code_point == CP_LF)  || (code_point == CP_VT) || (code_point == CP_FF) ||
         (code_point == CP_CR)  || (code_point == CP_NEL) ||
         (code_point == CP_LS)  || (code_point == CP_PS);
    sp = (code_point == CP_NUL)   || (code_point == CP_SPACE) ||
         (code_point == CP_TAB)   || (code_point == CP_NBSP) ||
         (code_point == CP_OGHAM) ||
         ((code_point >= CP_EN_QUAD) && (code_point <= CP_HAIR_SP)) ||
         (code_point == CP_NNBSP) || (code_point == CP_MMSP) ||
         (code_point == CP_IDEO_SP);
    flags.is_newline    = nl;
    flags.is_whitespace = sp || (nl && count_newlines);
  end

endmodule

@@ rtl/utf8_code_point_decoder_core.sv @@
// utf-8 code point decoder top level: input register, decode, result register
//
// channel | dir | transfer       | payload
// in_     | in  | one raw byte   | tdata[7:0] data_byte
// out_    | out | one code point | tdata code_point/byte_count, tuser flags
// cfg_    | in  | register write | data[0] count_newlines
//
// one byte is taken per cycle while in_tready is high; the input register feeds the sequence
// assembler and classifier, whose result is registered in the output register.
// a completed sequence shows on out_tvalid once its last byte has passed through the
// input register and its result has been written to the output register.
// when out_tready is low with a result held, the input register holds and in_tready
// drops only once it is also full.
// rst_n is synchronous; after reset count_newlines is 1 and no sequence is open.
module utf8_code_point_decoder_core
  import u8dec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata,  // [30:0] code_point, [33:31] byte_count
  output logic [FLAG_W-1:0]      out_tuser,  // [0] is_whitespace, [1] is_newline, [2] stray_byte
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data    // [0] count_newlines
);

  logic              count_nl_r;
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r, out_vld_nxt;
  u8dec_seq_res_t    out_res_r;
  u8dec_flags_t      out_flags_r;

  logic           out_free;
  logic           step;
  logic           res_vld;
  u8dec_seq_res_t res;
  u8dec_flags_t   flags;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || out_tready;
  assign step      = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_nl_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      count_nl_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  u8dec_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  u8dec_class u_class (
    .count_newlines (count_nl_r),
    .code_point     (res.code_point),
    .flags          (flags)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_free) begin
      out_vld_nxt = step && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      out_res_r   <= res;
      out_flags_r <= flags;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(TDATA_OUT_W-CP_W-LEN_W){1'b0}},
                       out_res_r.byte_count, out_res_r.code_point};
  assign out_tuser  = {out_res_r.stray_byte, out_flags_r.is_newline,
                       out_flags_r.is_whitespace};

  // a stray byte always reports code point zero, one byte, whitespace, no newline
  a_stray_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |->
      out_tdata[CP_W-1:0] == '0 && out_tdata[CP_W+LEN_W-1:CP_W] == LEN_ONE &&
      out_tuser[0] && !out_tuser[1])
    else $error("stray result malformed");

  // byte count stays within one to six
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CP_W+LEN_W-1:CP_W] != 3'd0 &&
                   out_tdata[CP_W+LEN_W-1:CP_W] != 3'd7)
    else $error("byte count out of range");

  // an accepted byte always occupies the input register next cycle
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> in_vld_r)
    else $error("accepted byte lost");

  // a held result is not overwritten by a new decode
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |-> !step)
    else $error("decode advanced into a full output register");

endmodule
